[src/point_in_polygon_test_defines.svh]
// Assertion macros for the point-in-polygon test block.
// Each one samples on clk and is switched off while rst_n is low.
`ifndef POINT_IN_POLYGON_TEST_DEFINES_SVH
`define POINT_IN_POLYGON_TEST_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PIP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PIP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/pip_pkg.sv]
`default_nettype none

package pip_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int CRD_W        = 24;
  localparam int DIF_W        = CRD_W + 1;
  localparam int PRD_W        = 2 * DIF_W;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_QUERY  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic signed [CRD_W-1:0] x_coord;
    logic signed [CRD_W-1:0] y_coord;
  } pip_in_t;

  typedef struct packed {
    logic inside_res;
    logic polygon_valid;
  } pip_out_t;

  typedef struct packed {
    logic signed [CRD_W-1:0] x;
    logic signed [CRD_W-1:0] y;
  } vtx_t;

  // vertex store write port
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    vtx_t             data;
  } vwr_t;

  // finished query handed to the output register
  typedef struct packed {
    logic valid;
    logic hit;
    logic poly_ok;
  } res_t;

endpackage

`default_nettype wire

[src/point_in_polygon_test.sv]
// Clear and append complete on acceptance; the block is ready again the next cycle.
// A query on n >= 3 vertices loads its result into the output register after one prepass
// read per vertex, the setup states P_LAST and V0, then the steps M1, M2 and DEC per edge
// on the single store read port and the one shared 25x25 multiplier.
// A query on fewer than three vertices goes straight to DONE and loads its result from there;
// ready returns with the load, and a full, stalled output register holds the block busy.
// Reset (rst_n, synchronous) empties the polygon; store contents stay undefined.
`default_nettype none

module point_in_polygon_test (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pip_pkg::pip_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pip_pkg::pip_out_t out_data
);

  logic                                   in_fire;
  logic                                   ctrl_idle;
  pip_pkg::vwr_t                          wr;
  logic [pip_pkg::IDX_W-1:0]              rd_addr;
  pip_pkg::vtx_t                          rd_data;
  logic signed [pip_pkg::DIF_W-1:0]       mul_a, mul_b;
  logic signed [pip_pkg::PRD_W-1:0]       mul_p;
  pip_pkg::res_t                          res;
  logic                                   res_ack;
  logic                                   out_valid_r;
  pip_pkg::pip_out_t                      out_data_r;

  assign in_ready = ctrl_idle;
  assign in_fire  = in_valid && in_ready;

  pip_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_data (in_data),
    .idle    (ctrl_idle),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .mul_a   (mul_a),
    .mul_b   (mul_b),
    .mul_p   (mul_p),
    .res     (res),
    .res_ack (res_ack)
  );

  pip_vstore u_vstore (
    .clk       (clk),
    .wr        (wr),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data)
  );

  pip_xmul u_xmul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (mul_p)
  );

  // load the output register when it is empty or being drained
  assign res_ack = res.valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ack) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ack) begin
      out_data_r <= '{inside_res: res.hit, polygon_valid: res.poly_ok};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[src/pip_vstore.sv]
`default_nettype none

module pip_vstore (
  input  logic                       clk,
  input  pip_pkg::vwr_t              wr,
  input  logic [pip_pkg::IDX_W-1:0]  rd_addr,
  output pip_pkg::vtx_t              rd_data_r
);

  pip_pkg::vtx_t mem [pip_pkg::MAX_VERTICES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[src/pip_xmul.sv]
`default_nettype none

module pip_xmul (
  input  logic                              clk,
  input  logic signed [pip_pkg::DIF_W-1:0]  mul_a,
  input  logic signed [pip_pkg::DIF_W-1:0]  mul_b,
  output logic signed [pip_pkg::PRD_W-1:0]  prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

endmodule

`default_nettype wire

[src/pip_ctrl.sv]
`default_nettype none

module pip_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_fire,
  input  pip_pkg::pip_in_t                  in_data,
  output logic                              idle,
  output pip_pkg::vwr_t                     wr,
  output logic [pip_pkg::IDX_W-1:0]         rd_addr,
  input  pip_pkg::vtx_t                     rd_data,
  output logic signed [pip_pkg::DIF_W-1:0]  mul_a,
  output logic signed [pip_pkg::DIF_W-1:0]  mul_b,
  input  logic signed [pip_pkg::PRD_W-1:0]  mul_p,
  output pip_pkg::res_t                     res,
  input  logic                              res_ack
);

  localparam int CW = pip_pkg::CRD_W;
  localparam int DW = pip_pkg::DIF_W;
  localparam int IW = pip_pkg::IDX_W;
  localparam int NW = pip_pkg::CNT_W;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_PRE    = 8'b0000_0010,
    ST_P_LAST = 8'b0000_0100,
    ST_V0     = 8'b0000_1000,
    ST_M1     = 8'b0001_0000,
    ST_M2     = 8'b0010_0000,
    ST_DEC    = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [NW-1:0]                cnt_r;
  logic [IW-1:0]                idx_r;
  logic                         pre_vld_r;
  logic signed [CW-1:0]         px_r, py_r;
  logic signed [CW-1:0]         x0_r, y0_r, x1_r, y1_r, x2_r, y2_r;
  logic signed [CW-1:0]         off_y_r;
  logic                         off_found_r;
  logic                         skip_r;
  logic signed [pip_pkg::PRD_W-1:0] lhs_r;
  logic                         parity_r;
  logic                         poly_ok_r;

  logic [IW-1:0]                last_idx;
  logic                         is_last;
  logic                         store_full;
  logic                         is_query;
  logic                         big_enough;
  logic signed [CW-1:0]         rd_x, rd_y, v2_x, v2_y;
  logic signed [DW-1:0]         d_py_y1, d_x2_x1, d_px_x1, d_y2_y1;
  logic                         on_line;
  logic                         skip_nxt;
  logic                         cmp_hit;
  logic                         count_hit;

  assign last_idx   = IW'(cnt_r - 1'b1);
  assign is_last    = (idx_r == last_idx);
  assign store_full = (cnt_r >= NW'(pip_pkg::MAX_VERTICES));
  assign is_query   = (in_data.kind == pip_pkg::KIND_QUERY);
  assign big_enough = (cnt_r >= NW'(3));

  assign rd_x = rd_data.x;
  assign rd_y = rd_data.y;
  // the closing edge wraps back to vertex 0
  assign v2_x = is_last ? x0_r : rd_x;
  assign v2_y = is_last ? y0_r : rd_y;

  assign d_py_y1 = {py_r[CW-1], py_r} - {y1_r[CW-1], y1_r};
  assign d_x2_x1 = {v2_x[CW-1], v2_x} - {x1_r[CW-1], x1_r};
  assign d_px_x1 = {px_r[CW-1], px_r} - {x1_r[CW-1], x1_r};
  assign d_y2_y1 = {y2_r[CW-1], y2_r} - {y1_r[CW-1], y1_r};

  // shared multiplier: (py-y1)*(x2-x1) in M1, (px-x1)*(y2-y1) in M2
  always_comb begin
    if (state_r == ST_M2) begin
      mul_a = d_px_x1;
      mul_b = d_y2_y1;
    end else begin
      mul_a = d_py_y1;
      mul_b = d_x2_x1;
    end
  end

  assign on_line = (py_r == y1_r);

  always_comb begin
    skip_nxt = ((x1_r < px_r) && (v2_x < px_r)) ||
               ((y1_r < py_r) && (v2_y < py_r)) ||
               ((y1_r > py_r) && (v2_y > py_r)) ||
               (y1_r == v2_y);
    // ray through the first vertex: drop the edge if the neighbors straddle the ray
    if (on_line) begin
      skip_nxt = skip_nxt || !off_found_r ||
                 ((off_y_r < py_r) && (v2_y > py_r)) ||
                 ((off_y_r > py_r) && (v2_y < py_r));
    end
  end

  assign cmp_hit   = (y2_r > y1_r) ? (lhs_r > mul_p) : (lhs_r < mul_p);
  assign count_hit = !skip_r && cmp_hit;

  always_comb begin
    unique case (state_r)
      ST_PRE:    rd_addr = idx_r;
      ST_P_LAST: rd_addr = '0;
      ST_V0:     rd_addr = IW'(1);
      ST_DEC:    rd_addr = idx_r + IW'(2);
      default:   rd_addr = idx_r;
    endcase
  end

  assign wr.en   = in_fire && (in_data.kind == pip_pkg::KIND_APPEND) && !store_full;
  assign wr.addr = cnt_r[IW-1:0];
  assign wr.data = '{x: in_data.x_coord, y: in_data.y_coord};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && is_query) begin
          state_nxt = big_enough ? ST_PRE : ST_DONE;
        end
      end
      ST_PRE: begin
        if (is_last) begin
          state_nxt = ST_P_LAST;
        end
      end
      ST_P_LAST: state_nxt = ST_V0;
      ST_V0:     state_nxt = ST_M1;
      ST_M1:     state_nxt = ST_M2;
      ST_M2:     state_nxt = ST_DEC;
      ST_DEC:    state_nxt = is_last ? ST_DONE : ST_M1;
      ST_DONE: begin
        if (res_ack) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      pre_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pre_vld_r <= (state_r == ST_PRE);
      if (in_fire) begin
        unique case (in_data.kind)
          pip_pkg::KIND_CLEAR:  cnt_r <= '0;
          pip_pkg::KIND_APPEND: begin
            if (!store_full) begin
              cnt_r <= cnt_r + 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && is_query) begin
          px_r        <= in_data.x_coord;
          py_r        <= in_data.y_coord;
          parity_r    <= 1'b0;
          poly_ok_r   <= big_enough;
          off_found_r <= 1'b0;
          idx_r       <= '0;
        end
      end
      ST_PRE: begin
        // prepass: remember the highest-index vertex off the ray's line
        if (pre_vld_r && (rd_y != py_r)) begin
          off_y_r     <= rd_y;
          off_found_r <= 1'b1;
        end
        if (!is_last) begin
          idx_r <= idx_r + 1'b1;
        end
      end
      ST_P_LAST: begin
        if (rd_y != py_r) begin
          off_y_r     <= rd_y;
          off_found_r <= 1'b1;
        end
      end
      ST_V0: begin
        x0_r  <= rd_x;
        y0_r  <= rd_y;
        x1_r  <= rd_x;
        y1_r  <= rd_y;
        idx_r <= '0;
      end
      ST_M1: begin
        x2_r   <= v2_x;
        y2_r   <= v2_y;
        skip_r <= skip_nxt;
      end
      ST_M2: begin
        lhs_r <= mul_p;
      end
      ST_DEC: begin
        parity_r <= parity_r ^ count_hit;
        if (y1_r != py_r) begin
          off_y_r     <= y1_r;
          off_found_r <= 1'b1;
        end
        x1_r  <= x2_r;
        y1_r  <= y2_r;
        idx_r <= idx_r + 1'b1;
      end
      default: ;
    endcase
  end

  assign idle = (state_r == ST_IDLE);
  assign res  = '{valid: (state_r == ST_DONE), hit: parity_r & poly_ok_r, poly_ok: poly_ok_r};

endmodule

`default_nettype wire

[src/pip_chk.sv]
`default_nettype none
`include "point_in_polygon_test_defines.svh"

module pip_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input pip_pkg::pip_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input pip_pkg::pip_out_t out_data
);

  logic in_fire;
  logic query_fire;

  assign in_fire    = in_valid && in_ready;
  assign query_fire = in_fire && (in_data.kind == pip_pkg::KIND_QUERY);

  `PIP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result transaction dropped or changed while stalled")
  `PIP_ASSERT_NOW(a_small_outside, out_valid && !out_data.polygon_valid, !out_data.inside_res, "inside reported for a polygon under three vertices")
  `PIP_ASSERT_NEXT(a_query_busy, query_fire, !in_ready, "ready stayed high right after a query")
  `PIP_ASSERT_NEXT(a_edit_silent, in_fire && !query_fire, !$rose(out_valid), "result appeared right after a clear or append")

endmodule

bind point_in_polygon_test pip_chk u_pip_chk (.*);

`default_nettype wire

[test/tb_point_in_polygon_test.sv]
`timescale 1ns / 1ps

module tb_point_in_polygon_test;

  localparam int CRD_W = pip_pkg::CRD_W;
  localparam int MAX_VERTICES = pip_pkg::MAX_VERTICES;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic signed [CRD_W-1:0] CRD_MIN = {1'b1, {(CRD_W-1){1'b0}}};
  localparam logic signed [CRD_W-1:0] CRD_MAX = {1'b0, {(CRD_W-1){1'b1}}};
  localparam int RANDOM_ITEMS = 1250;
  localparam int NUM_PHASES = 8;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  pip_pkg::pip_in_t  in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  pip_pkg::pip_out_t out_data;

  point_in_polygon_test dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #4 clk = ~clk;

  // polygon as the block should hold it
  int poly_x [MAX_VERTICES];
  int poly_y [MAX_VERTICES];
  int poly_count = 0;

  pip_pkg::pip_in_t  pending_ops[$];
  pip_pkg::pip_out_t expected_verdicts[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int queries_answered = 0;

  function automatic bit edge_crosses(int px, int py, int i);
    int n, j, x1, y1, x2, y2, prev_y;
    bit found;
    longint dy, lhs, rhs;
    n = poly_count;
    j = (i + 1) % n;
    x1 = poly_x[i];
    y1 = poly_y[i];
    x2 = poly_x[j];
    y2 = poly_y[j];
    if (x1 < px && x2 < px) return 1'b0;
    if (y1 < py && y2 < py) return 1'b0;
    if (y1 > py && y2 > py) return 1'b0;
    if (y1 == y2) return 1'b0;
    if (py == y1) begin
      // ray passes through the first end: look back for a vertex off the ray
      found = 1'b0;
      prev_y = 0;
      for (int k = 1; k < n && !found; k++) begin
        if (poly_y[(i + n - k) % n] != py) begin
          prev_y = poly_y[(i + n - k) % n];
          found = 1'b1;
        end
      end
      if (!found) return 1'b0;
      if ((prev_y < py && y2 > py) || (prev_y > py && y2 < py)) return 1'b0;
    end
    dy  = longint'(y2) - longint'(y1);
    lhs = (longint'(py) - longint'(y1)) * (longint'(x2) - longint'(x1));
    rhs = (longint'(px) - longint'(x1)) * dy;
    return (dy > 0) ? (lhs > rhs) : (lhs < rhs);
  endfunction

  function automatic pip_pkg::pip_out_t polygon_verdict(int px, int py);
    pip_pkg::pip_out_t v;
    int crossings;
    v = '0;
    crossings = 0;
    if (poly_count >= 3) begin
      for (int i = 0; i < poly_count; i++) crossings += edge_crosses(px, py, i);
      v.inside_res = crossings[0];
      v.polygon_valid = 1'b1;
    end
    return v;
  endfunction

  function automatic void commit_op(pip_pkg::pip_in_t t);
    case (t.kind)
      pip_pkg::KIND_CLEAR: poly_count = 0;
      pip_pkg::KIND_APPEND: begin
        if (poly_count < MAX_VERTICES) begin
          poly_x[poly_count] = int'(t.x_coord);
          poly_y[poly_count] = int'(t.y_coord);
          poly_count++;
        end
      end
      pip_pkg::KIND_QUERY:
        expected_verdicts.push_back(polygon_verdict(int'(t.x_coord), int'(t.y_coord)));
      default: ;
    endcase
  endfunction

  function automatic pip_pkg::pip_in_t make_op(logic [1:0] k, logic signed [CRD_W-1:0] x,
                                               logic signed [CRD_W-1:0] y);
    pip_pkg::pip_in_t t;
    t.kind = k;
    t.x_coord = x;
    t.y_coord = y;
    return t;
  endfunction

  // mode 0 grid, 1 full range, 2 extremes, 3 any of these per coordinate
  function automatic logic signed [CRD_W-1:0] pick_coord(int mode, int step);
    int m;
    m = (mode == 3) ? int'($urandom_range(2)) : mode;
    case (m)
      0: return CRD_W'((int'($urandom_range(8)) - 4) * step);
      1: return CRD_W'($urandom());
      default: begin
        case ($urandom_range(4))
          0: return CRD_MIN;
          1: return CRD_MAX;
          2: return CRD_W'(-1);
          3: return '0;
          default: return CRD_W'(1);
        endcase
      end
    endcase
  endfunction

  task automatic queue_session(output int meaningful);
    int r, n, mode, step, pick;
    logic [1:0] k;
    logic signed [CRD_W-1:0] sx [MAX_VERTICES+7];
    logic signed [CRD_W-1:0] sy [MAX_VERTICES+7];
    logic signed [CRD_W-1:0] qx, qy;
    meaningful = 0;
    r = $urandom_range(99);
    if (r < 8) begin
      // noise: random kinds, unused kind among them
      repeat ($urandom_range(6, 1)) begin
        k = 2'($urandom_range(3));
        pending_ops.push_back(make_op(k, CRD_W'($urandom()), CRD_W'($urandom())));
        if (k != KIND_UNUSED) meaningful++;
      end
      return;
    end
    // a few sessions keep appending onto the previous polygon
    if (r >= 14) begin
      pending_ops.push_back(make_op(pip_pkg::KIND_CLEAR, CRD_W'($urandom()),
                                    CRD_W'($urandom())));
      meaningful++;
    end
    r = $urandom_range(99);
    if (r < 60) n = $urandom_range(8, 3);
    else if (r < 75) n = $urandom_range(2);
    else if (r < 92) n = $urandom_range(30, 9);
    else n = $urandom_range(MAX_VERTICES + 6, MAX_VERTICES - 4);
    mode = $urandom_range(3);
    step = $urandom_range(1) ? 256 : int'($urandom_range(1000000, 1));
    for (int i = 0; i < n; i++) begin
      sx[i] = pick_coord(mode, step);
      sy[i] = pick_coord(mode, step);
      pending_ops.push_back(make_op(pip_pkg::KIND_APPEND, sx[i], sy[i]));
      if (i < MAX_VERTICES) meaningful++;
    end
    repeat ($urandom_range(6, 1)) begin
      qx = pick_coord(mode, step);
      qy = pick_coord(mode, step);
      if (n > 0 && $urandom_range(99) < 40) begin
        // aim the ray at a vertex
        pick = $urandom_range(n - 1);
        qy = sy[pick];
        if ($urandom_range(1)) qx = sx[pick] - CRD_W'($urandom_range(3));
      end
      pending_ops.push_back(make_op(pip_pkg::KIND_QUERY, qx, qy));
      meaningful++;
    end
  endtask

  task automatic drain();
    while (pending_ops.size() != 0 || in_valid || expected_verdicts.size() != 0)
      @(posedge clk);
  endtask

  task automatic note_mismatch(string what, pip_pkg::pip_out_t want, pip_pkg::pip_out_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch (%s) at query %0d: expected inside=%b valid=%b, got inside=%b valid=%b",
               what, queries_answered, want.inside_res, want.polygon_valid,
               got.inside_res, got.polygon_valid);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) commit_op(in_data);
      if (!in_valid || in_ready) begin
        if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= pending_ops.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        queries_answered++;
        if (expected_verdicts.size() == 0) begin
          note_mismatch("no query pending", '0, out_data);
        end else if (out_data.inside_res !== expected_verdicts[0].inside_res ||
                     out_data.polygon_valid !== expected_verdicts[0].polygon_valid) begin
          note_mismatch("wrong field", expected_verdicts.pop_front(), out_data);
        end else begin
          void'(expected_verdicts.pop_front());
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    int produced, got;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty and small polygons, unused kind, extreme triangle, vertex hits
    pending_ops.push_back(make_op(pip_pkg::KIND_QUERY, '0, '0));
    pending_ops.push_back(make_op(pip_pkg::KIND_APPEND, CRD_MIN, CRD_MIN));
    pending_ops.push_back(make_op(pip_pkg::KIND_QUERY, CRD_MAX, CRD_MAX));
    pending_ops.push_back(make_op(pip_pkg::KIND_APPEND, CRD_MAX, CRD_MIN));
    pending_ops.push_back(make_op(KIND_UNUSED, CRD_MAX, CRD_MAX));
    pending_ops.push_back(make_op(pip_pkg::KIND_QUERY, '0, '0));
    pending_ops.push_back(make_op(pip_pkg::KIND_APPEND, '0, CRD_MAX));
    pending_ops.push_back(make_op(pip_pkg::KIND_QUERY, '0, '0));
    pending_ops.push_back(make_op(pip_pkg::KIND_QUERY, CRD_MAX, CRD_MAX));
    pending_ops.push_back(make_op(pip_pkg::KIND_QUERY, CRD_MIN, '0));
    pending_ops.push_back(make_op(pip_pkg::KIND_QUERY, '0, CRD_MIN));
    pending_ops.push_back(make_op(pip_pkg::KIND_QUERY, CRD_W'(-1), CRD_MAX));
    pending_ops.push_back(make_op(pip_pkg::KIND_QUERY, CRD_MIN, CRD_MIN));
    pending_ops.push_back(make_op(pip_pkg::KIND_CLEAR, '0, '0));
    pending_ops.push_back(make_op(pip_pkg::KIND_QUERY, '0, '0));
    pending_ops.push_back(make_op(pip_pkg::KIND_APPEND, '0, '0));
    pending_ops.push_back(make_op(pip_pkg::KIND_APPEND, CRD_W'(512), '0));
    pending_ops.push_back(make_op(pip_pkg::KIND_APPEND, CRD_W'(512), CRD_W'(512)));
    pending_ops.push_back(make_op(pip_pkg::KIND_APPEND, CRD_W'(256), CRD_W'(256)));
    pending_ops.push_back(make_op(pip_pkg::KIND_APPEND, '0, CRD_W'(512)));
    pending_ops.push_back(make_op(pip_pkg::KIND_QUERY, CRD_W'(256), CRD_W'(128)));
    pending_ops.push_back(make_op(pip_pkg::KIND_QUERY, CRD_W'(-256), '0));
    pending_ops.push_back(make_op(pip_pkg::KIND_QUERY, CRD_W'(-256), CRD_W'(256)));
    pending_ops.push_back(make_op(pip_pkg::KIND_QUERY, CRD_W'(128), CRD_W'(512)));
    pending_ops.push_back(make_op(pip_pkg::KIND_QUERY, CRD_W'(600), CRD_W'(256)));
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct <= 66; recv_stall_pct <= 0;  end
        2: begin send_idle_pct <= 0;  recv_stall_pct <= 66; end
        default: begin send_idle_pct <= 18; recv_stall_pct <= 18; end
      endcase
      produced = 0;
      while (produced < RANDOM_ITEMS / NUM_PHASES) begin
        queue_session(got);
        produced += got;
      end
      // hold the next phase until every verdict of this one is back
      drain();
    end

    repeat (300) @(posedge clk);
    if (expected_verdicts.size() != 0) begin
      $display("%0d queries never answered", expected_verdicts.size());
      mismatches += expected_verdicts.size();
    end
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/pip_pkg.sv
src/pip_vstore.sv
src/pip_xmul.sv
src/pip_ctrl.sv
src/point_in_polygon_test.sv
src/pip_chk.sv
test/tb_point_in_polygon_test.sv
